>>> sv/uwrap_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 word wrapper package
// Shared types, register indexes and constants of the word wrapper blocks.
// ----------------------------------------------------------------------------
package uwrap_pkg;

  localparam int MAX_TEXT_BYTES = 4096;
  localparam int POS_W          = $clog2(MAX_TEXT_BYTES + 1);
  localparam int START_W        = 12;
  localparam int LEN_W          = 13;
  localparam int CNT_W          = 7;
  localparam int WID_W          = 13;
  localparam int WSUM_W         = WID_W + 1;
  localparam int MAX_RESULTS    = 3;
  localparam int RES_CNT_W      = 2;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);

  localparam logic [WID_W-1:0] WIDTH_MAX = '1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_LIMIT = 2'd1;

  localparam logic [7:0] WRAP_WIDTH_RESET = 8'd20;
  localparam logic [6:0] LINE_LIMIT_RESET = 7'd8;

  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CONT_MASK    = 8'hC0;
  localparam logic [7:0] CONT_MARK    = 8'h80;

  localparam logic KIND_LINE    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       is_end;
  } in_t;

  typedef struct packed {
    logic               kind;
    logic [START_W-1:0] line_start;
    logic [LEN_W-1:0]   line_length;
    logic [CNT_W-1:0]   line_count;
    logic               truncated;
    logic               last_of_run;
  } out_t;

  // All results caused by one text item, packed from slot zero upward.
  typedef struct packed {
    logic [RES_CNT_W-1:0]         cnt;
    out_t [MAX_RESULTS-1:0]       res;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

>>> sv/uwrap_front.sv
// ----------------------------------------------------------------------------
// Word wrapper front end
// Accepts text items, tracks line and word state and makes the greedy
// fit-or-wrap decision, producing one queue entry per item with results.
// ----------------------------------------------------------------------------
module uwrap_front import uwrap_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  text_valid,
  output logic                  text_stall,
  input  in_t                   text_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  queue_stat_t           qstat,
  output logic                  push,
  output entry_t                push_entry
);

  logic [7:0]       wrap_width;
  logic [6:0]       line_limit;
  logic [POS_W-1:0] byte_position;
  logic [POS_W-1:0] cur_line_start;
  logic [POS_W-1:0] cur_word_start;
  logic [WID_W-1:0] line_width;
  logic [WID_W-1:0] word_width;
  logic [CNT_W-1:0] lines_emitted;
  logic             overflow_seen;

  logic              accept;
  logic              is_space;
  logic              is_nl;
  logic              is_cont;
  logic              in_range;
  logic              room;
  logic              room_a;
  logic              dec_en;
  logic              fit;
  logic              wrap;
  logic              emit2;
  logic [WSUM_W-1:0] fit_sum;
  logic [POS_W-1:0]  wrap_len;
  logic [POS_W-1:0]  len2;
  logic [POS_W-1:0]  ls_a;
  logic [WID_W-1:0]  lw_a;
  logic [CNT_W-1:0]  lines_a;
  logic [CNT_W-1:0]  lines_b;
  logic [POS_W-1:0]  pos_inc;
  logic [RES_CNT_W-1:0] n;
  entry_t            entry;

  function automatic out_t mk_res(logic kind, logic [POS_W-1:0] start,
                                  logic [POS_W-1:0] len, logic [CNT_W-1:0] cnt,
                                  logic trunc);
    out_t r;
    r.kind        = kind;
    r.line_start  = START_W'(start);
    r.line_length = LEN_W'(len);
    r.line_count  = cnt;
    r.truncated   = trunc;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  assign text_stall = qstat.full;
  assign accept     = text_valid && !text_stall;

  always_comb begin
    is_space = (text_item.text_byte == CHAR_SPACE);
    is_nl    = (text_item.text_byte == CHAR_NEWLINE);
    is_cont  = ((text_item.text_byte & CONT_MASK) == CONT_MARK);
    in_range = (byte_position < POS_W'(MAX_TEXT_BYTES));
    room     = (lines_emitted < line_limit);
    pos_inc  = byte_position + 1'b1;

    if (text_item.is_end) begin
      dec_en = room && (byte_position > cur_word_start);
    end else begin
      dec_en = in_range && room &&
               (is_space || (is_nl && (byte_position > cur_word_start)));
    end

    // First word of a line is always taken; otherwise it must fit with a space.
    fit_sum = {1'b0, line_width} + {1'b0, word_width} + WSUM_W'(1);
    fit     = (line_width == '0) || (fit_sum <= {{(WSUM_W-8){1'b0}}, wrap_width});
    wrap    = dec_en && !fit;

    wrap_len = (cur_word_start > cur_line_start) ?
               (cur_word_start - 1'b1 - cur_line_start) : '0;
    lines_a  = lines_emitted + CNT_W'(wrap);
    ls_a     = wrap ? cur_word_start : cur_line_start;
    if (!dec_en) begin
      lw_a = line_width;
    end else if ((line_width == '0) || wrap) begin
      lw_a = word_width;
    end else begin
      lw_a = fit_sum[WID_W-1:0];
    end
    room_a = (lines_a < line_limit);

    if (text_item.is_end) begin
      emit2 = room_a && (ls_a < byte_position);
    end else begin
      emit2 = in_range && room && is_nl && room_a;
    end
    len2    = (byte_position > ls_a) ? (byte_position - ls_a) : '0;
    lines_b = lines_a + CNT_W'(emit2);

    entry = '0;
    n     = '0;
    if (accept && wrap) begin
      entry.res[n] = mk_res(KIND_LINE, cur_line_start, wrap_len,
                            lines_emitted + 1'b1, 1'b0);
      n = n + 1'b1;
    end
    if (accept && emit2) begin
      entry.res[n] = mk_res(KIND_LINE, ls_a, len2, lines_a + 1'b1, 1'b0);
      n = n + 1'b1;
    end
    if (accept && text_item.is_end) begin
      entry.res[n] = mk_res(KIND_SUMMARY, '0, '0, lines_b, overflow_seen);
      n = n + 1'b1;
    end
    if (n != '0) begin
      entry.res[n - 1'b1].last_of_run = 1'b1;
    end
    entry.cnt  = n;
    push       = (n != '0);
    push_entry = entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_width <= WRAP_WIDTH_RESET;
      line_limit <= LINE_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WRAP_WIDTH: wrap_width <= cfg_data[7:0];
        REG_LINE_LIMIT: line_limit <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      cur_line_start <= '0;
      cur_word_start <= '0;
      line_width     <= '0;
      word_width     <= '0;
      lines_emitted  <= '0;
      overflow_seen  <= 1'b0;
    end else if (accept) begin
      if (text_item.is_end) begin
        // The end marker returns the text state to its reset values.
        byte_position  <= '0;
        cur_line_start <= '0;
        cur_word_start <= '0;
        line_width     <= '0;
        word_width     <= '0;
        lines_emitted  <= '0;
        overflow_seen  <= 1'b0;
      end else if (!in_range) begin
        overflow_seen <= 1'b1;
      end else begin
        byte_position <= pos_inc;
        if (room) begin
          if (is_space) begin
            cur_line_start <= ls_a;
            line_width     <= lw_a;
            lines_emitted  <= lines_a;
            cur_word_start <= pos_inc;
            word_width     <= '0;
          end else if (is_nl) begin
            lines_emitted  <= lines_b;
            cur_line_start <= pos_inc;
            cur_word_start <= pos_inc;
            line_width     <= '0;
            word_width     <= '0;
          end else if (!is_cont) begin
            word_width <= (word_width == WIDTH_MAX) ? word_width : word_width + 1'b1;
          end
        end
      end
    end
  end

endmodule

>>> sv/uwrap_queue.sv
// ----------------------------------------------------------------------------
// Word wrapper result queue
// Small first-in first-out buffer of result entries between front and back.
// ----------------------------------------------------------------------------
module uwrap_queue import uwrap_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  entry_t      push_entry,
  input  logic        pop,
  output entry_t      head,
  output queue_stat_t qstat
);

  entry_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QPTR_W:0]    count;

  assign qstat.full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign qstat.empty = (count == '0);
  assign head        = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

endmodule

>>> sv/uwrap_back.sv
// ----------------------------------------------------------------------------
// Word wrapper back end
// Takes queue entries and hands out their results one per output item.
// ----------------------------------------------------------------------------
module uwrap_back import uwrap_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  entry_t      head,
  input  queue_stat_t qstat,
  output logic        pop,
  output logic        res_valid,
  input  logic        res_stall,
  output out_t        res_item
);

  entry_t               cur;
  logic [RES_CNT_W-1:0] idx;
  logic                 busy;
  logic                 done_one;
  logic                 load;

  assign done_one  = busy && !res_stall;
  // A new entry loads when no entry is held or when the last result of the current one leaves.
  assign load      = !busy || (done_one && (idx == cur.cnt - 1'b1));
  assign pop       = load && !qstat.empty;
  assign res_valid = busy;
  assign res_item  = cur.res[idx];

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= !qstat.empty;
      idx  <= '0;
    end else if (done_one) begin
      idx <= idx + 1'b1;
    end
  end

endmodule

>>> sv/utf8_greedy_word_wrapper_core.sv
// ----------------------------------------------------------------------------
// UTF-8 greedy word wrapper
// The block accepts one text byte or end marker per clock cycle and breaks the
// text into lines with a greedy rule, counting width in UTF-8 characters.
// Each finished line leaves as one result item, and every end marker yields a
// summary item. An input item is taken in the cycle it arrives as long as the
// four-entry result queue has room; each result is registered in the queue
// and then in the back end before it appears at the output. The output side
// moves one result per cycle while the output is not stalled, and a byte
// stream with no more than one result per byte runs at one byte per cycle
// under that condition. Configuration must be written through the plain
// write port only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module utf8_greedy_word_wrapper_core import uwrap_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  text_valid,
  output logic                  text_stall,
  input  in_t                   text_item,
  output logic                  res_valid,
  input  logic                  res_stall,
  output out_t                  res_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  queue_stat_t qstat;
  logic        push;
  logic        pop;
  entry_t      push_entry;
  entry_t      head;

  uwrap_front u_front (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text_item  (text_item),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .qstat      (qstat),
    .push       (push),
    .push_entry (push_entry)
  );

  uwrap_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  uwrap_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

endmodule

>>> sv/uwrap_checker.sv
// ----------------------------------------------------------------------------
// Word wrapper port checker
// Watches the result port of the word wrapper over time.
// ----------------------------------------------------------------------------
module uwrap_checker import uwrap_pkg::*; (
  input logic clk,
  input logic rst,
  input logic res_valid,
  input logic res_stall,
  input out_t res_item
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_item))
    else $error("result item changed while stalled");

  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_item.kind == KIND_SUMMARY) |-> res_item.last_of_run)
    else $error("summary item is not the last of its run");

  a_summary_empty: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_item.kind == KIND_SUMMARY) |->
      (res_item.line_start == '0) && (res_item.line_length == '0))
    else $error("summary item carries line data");

  a_line_untrunc: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_item.kind == KIND_LINE) |->
      !res_item.truncated && (res_item.line_count != '0))
    else $error("line item has a bad truncated flag or count");

endmodule

bind utf8_greedy_word_wrapper_core uwrap_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res_item  (res_item)
);

>>> tb/utf8_greedy_word_wrapper_core_tb.sv
// ----------------------------------------------------------------------------
// UTF-8 greedy word wrapper testbench
// Feeds text bytes and end markers into the wrapper and checks every line and
// summary it returns against a cycle-free model of the greedy wrap rule kept
// inside this bench. A short directed part covers spaces, newlines, multibyte
// characters and the register corners. Random texts follow over several
// register settings. Both sides idle at random.
// ----------------------------------------------------------------------------
module utf8_greedy_word_wrapper_core_tb;
  import uwrap_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Indexes that decode to no register; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
  localparam int POST_CYCLES = 8;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  text_valid = 1'b0;
  logic                  text_stall;
  in_t                   text_item = '0;
  logic                  res_valid;
  logic                  res_stall = 1'b0;
  out_t                  res_item;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  utf8_greedy_word_wrapper_core dut (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text_item  (text_item),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_item   (res_item),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  // Register copies and running text state of the wrap model.
  logic [7:0]  reg_line_chars = WRAP_WIDTH_RESET;
  logic [6:0]  reg_lines      = LINE_LIMIT_RESET;
  logic [12:0] wr_pos         = '0;
  logic [12:0] wr_line_start  = '0;
  logic [12:0] wr_word_start  = '0;
  logic [12:0] wr_line_w      = '0;
  logic [12:0] wr_word_w      = '0;
  logic [6:0]  wr_lines       = '0;
  logic        wr_overflow    = 1'b0;

  out_t step_results[$];
  out_t awaited_results[$];
  in_t  text_backlog[$];

  bit idle_on   = 1'b1;
  bit text_busy = 1'b0;
  bit text_done = 1'b0;
  bit res_done  = 1'b0;
  int text_gap  = 0;
  int res_wait  = 0;

  int errors          = 0;
  int items_queued    = 0;
  int items_accepted  = 0;
  int lines_checked   = 0;
  int summaries_seen  = 0;
  int settings_used   = 1;

  task automatic close_line(logic [12:0] start, logic [12:0] len);
    out_t r;
    wr_lines = wr_lines + 7'd1;
    r.kind        = KIND_LINE;
    r.line_start  = start[START_W-1:0];
    r.line_length = len;
    r.line_count  = wr_lines;
    r.truncated   = 1'b0;
    r.last_of_run = 1'b0;
    step_results.push_back(r);
  endtask

  // Greedy fit-or-wrap decision for the word that just ended.
  task automatic judge_word();
    int          sum;
    logic [12:0] len;
    sum = int'(wr_line_w) + int'(wr_word_w) + 1;
    if (wr_line_w == 0) begin
      wr_line_w = wr_word_w;
    end else if (sum <= int'(reg_line_chars)) begin
      wr_line_w = (sum > WIDTH_MAX) ? WIDTH_MAX : 13'(sum);
    end else begin
      len = (wr_word_start > wr_line_start) ? wr_word_start - 13'd1 - wr_line_start : 13'd0;
      close_line(wr_line_start, len);
      wr_line_start = wr_word_start;
      wr_line_w     = wr_word_w;
    end
  endtask

  task automatic wrap_text_item(in_t it);
    logic [12:0] at;
    out_t        r;
    step_results.delete();
    if (it.is_end) begin
      if (wr_lines < reg_lines && wr_pos > wr_word_start)
        judge_word();
      if (wr_lines < reg_lines && wr_line_start < wr_pos)
        close_line(wr_line_start, wr_pos - wr_line_start);
      r.kind        = KIND_SUMMARY;
      r.line_start  = '0;
      r.line_length = '0;
      r.line_count  = wr_lines;
      r.truncated   = wr_overflow;
      r.last_of_run = 1'b0;
      step_results.push_back(r);
      wr_pos        = '0;
      wr_line_start = '0;
      wr_word_start = '0;
      wr_line_w     = '0;
      wr_word_w     = '0;
      wr_lines      = '0;
      wr_overflow   = 1'b0;
    end else if (wr_pos >= MAX_TEXT_BYTES) begin
      wr_overflow = 1'b1;
    end else begin
      at     = wr_pos;
      wr_pos = at + 13'd1;
      // Once the line limit is hit, bytes only advance the position.
      if (wr_lines < reg_lines) begin
        if (it.text_byte == CHAR_SPACE) begin
          judge_word();
          wr_word_start = at + 13'd1;
          wr_word_w     = '0;
        end else if (it.text_byte == CHAR_NEWLINE) begin
          if (at > wr_word_start)
            judge_word();
          if (wr_lines < reg_lines)
            close_line(wr_line_start, (at > wr_line_start) ? at - wr_line_start : 13'd0);
          wr_line_start = at + 13'd1;
          wr_word_start = at + 13'd1;
          wr_line_w     = '0;
          wr_word_w     = '0;
        end else if ((it.text_byte & CONT_MASK) != CONT_MARK && wr_word_w != WIDTH_MAX) begin
          wr_word_w = wr_word_w + 13'd1;
        end
      end
    end
    if (step_results.size() != 0) begin
      r = step_results.pop_back();
      r.last_of_run = 1'b1;
      step_results.push_back(r);
    end
    foreach (step_results[i])
      awaited_results.push_back(step_results[i]);
  endtask

  task automatic report_mismatch(string msg);
    errors++;
    $display("[%0t] result %0d: %s", $time, lines_checked + summaries_seen, msg);
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want)
      report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  // Sampling of both handshakes, prediction and checking.
  always @(posedge clk) begin
    if (!rst) begin
      if (text_valid && !text_stall) begin
        wrap_text_item(text_item);
        items_accepted++;
        text_done = 1'b1;
      end
      if (res_valid && !res_stall) begin
        res_done = 1'b1;
        if (awaited_results.size() == 0) begin
          report_mismatch("result arrived with nothing expected");
        end else begin
          check_field("kind", res_item.kind, awaited_results[0].kind);
          check_field("line_start", res_item.line_start, awaited_results[0].line_start);
          check_field("line_length", res_item.line_length, awaited_results[0].line_length);
          check_field("line_count", res_item.line_count, awaited_results[0].line_count);
          check_field("truncated", res_item.truncated, awaited_results[0].truncated);
          check_field("last_of_run", res_item.last_of_run, awaited_results[0].last_of_run);
          if (awaited_results[0].kind == KIND_SUMMARY)
            summaries_seen++;
          else
            lines_checked++;
          void'(awaited_results.pop_front());
        end
      end
    end
  end

  // Text driver: one gap drawn per item, then the item is held until taken.
  always @(negedge clk) begin
    if (!rst) begin
      if (text_done) begin
        text_done = 1'b0;
        text_busy = 1'b0;
        text_gap  = idle_on ? $urandom_range(0, 19) : 0;
      end
      if (!text_busy) begin
        if (text_gap != 0) begin
          text_gap--;
        end else if (text_backlog.size() != 0) begin
          text_item <= text_backlog.pop_front();
          text_busy = 1'b1;
        end
      end
    end
    text_valid <= text_busy;
  end

  // Result receiver: stalls for a drawn number of cycles after each result.
  always @(negedge clk) begin
    if (res_done) begin
      res_done = 1'b0;
      res_wait = idle_on ? $urandom_range(0, 19) : 0;
    end
    res_stall <= (res_wait != 0);
    if (res_wait != 0)
      res_wait--;
  end

  task automatic queue_byte(logic [7:0] b);
    in_t it;
    it.text_byte = b;
    it.is_end    = 1'b0;
    text_backlog.push_back(it);
    items_queued++;
  endtask

  // The byte carried with an end marker is random since it must be ignored.
  task automatic queue_end();
    in_t it;
    it.text_byte = 8'($urandom_range(0, 255));
    it.is_end    = 1'b1;
    text_backlog.push_back(it);
    items_queued++;
  endtask

  // One character: mostly ASCII, some multibyte sequences, some raw noise.
  task automatic queue_char();
    int n;
    case ($urandom_range(0, 9))
      6: begin
        queue_byte(8'($urandom_range(8'hC2, 8'hDF)));
        n = 1;
      end
      7: begin
        queue_byte(8'($urandom_range(8'hE0, 8'hEF)));
        n = 2;
      end
      8: begin
        queue_byte(8'($urandom_range(8'hF0, 8'hF4)));
        n = 3;
      end
      9: begin
        queue_byte(8'($urandom_range(0, 255)));
        n = 0;
      end
      default: begin
        queue_byte(8'($urandom_range(8'h21, 8'h7E)));
        n = 0;
      end
    endcase
    repeat (n) queue_byte(8'($urandom_range(8'h80, 8'hBF)));
  endtask

  task automatic queue_text(int words, int word_max);
    if ($urandom_range(0, 5) == 0)
      queue_byte(CHAR_SPACE);
    for (int w = 0; w < words; w++) begin
      repeat ($urandom_range(1, word_max)) queue_char();
      if (w != words - 1 || $urandom_range(0, 1) == 1) begin
        case ($urandom_range(0, 9))
          0: queue_byte(CHAR_NEWLINE);
          1: begin
            queue_byte(CHAR_SPACE);
            queue_byte(CHAR_SPACE);
          end
          2: begin
            queue_byte(CHAR_NEWLINE);
            queue_byte(CHAR_NEWLINE);
          end
          default: queue_byte(CHAR_SPACE);
        endcase
      end
    end
    queue_end();
  endtask

  task automatic wait_idle();
    while (text_backlog.size() != 0 || text_busy || awaited_results.size() != 0)
      @(negedge clk);
    repeat (POST_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == REG_WRAP_WIDTH)
      reg_line_chars = data;
    else if (idx == REG_LINE_LIMIT)
      reg_lines = data[6:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Bit 7 of a line-count write is random; the register keeps only 7 bits.
  task automatic apply_setting(logic [7:0] line_chars, logic [6:0] lines, bit idle);
    wait_idle();
    write_reg(REG_WRAP_WIDTH, line_chars);
    write_reg(REG_LINE_LIMIT, {1'($urandom_range(0, 1)), lines});
    idle_on = idle;
    settings_used++;
  endtask

  initial begin : stimulus
    int         mark;
    logic [7:0] line_chars;
    logic [6:0] lines;
    bit         idle;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: leading and doubled spaces, multibyte and stray
    // continuation bytes, a zero byte, an empty line and a word left at the end.
    queue_byte(CHAR_SPACE);
    queue_byte(8'h61);
    queue_byte(CHAR_SPACE);
    queue_byte(CHAR_SPACE);
    queue_byte(8'hC3);
    queue_byte(8'hA9);
    queue_byte(8'h00);
    queue_byte(CHAR_NEWLINE);
    queue_byte(CHAR_NEWLINE);
    queue_byte(8'hFF);
    queue_byte(8'h7F);
    queue_byte(CHAR_SPACE);
    queue_byte(8'h80);
    queue_end();

    // A zero width limit wraps the second word, and one line stops the text.
    apply_setting(8'd0, 7'd1, 1'b1);
    queue_byte(8'h61);
    queue_byte(8'h62);
    queue_byte(CHAR_SPACE);
    queue_byte(8'h63);
    queue_byte(8'h64);
    queue_byte(CHAR_NEWLINE);
    queue_byte(8'h78);
    queue_end();

    // No lines allowed at all; writes to unused indexes change nothing.
    wait_idle();
    write_reg(REG_WRAP_WIDTH, 8'd255);
    write_reg(REG_LINE_LIMIT, 8'h80);
    write_reg(REG_SPARE_LO, 8'($urandom_range(0, 255)));
    write_reg(REG_SPARE_HI, 8'($urandom_range(0, 255)));
    settings_used++;
    queue_byte(8'h61);
    queue_end();

    // One-character limit with 16 lines: every word wraps until the limit.
    apply_setting(8'd1, 7'd16, 1'b1);
    repeat (20) begin
      queue_char();
      queue_byte(CHAR_SPACE);
    end
    queue_end();

    for (int s = 0; s < 5; s++) begin
      case (s)
        0: begin
          line_chars = 8'd255;
          lines      = 7'd1;
          idle       = 1'b1;
        end
        1: begin
          line_chars = 8'($urandom_range(2, 16));
          lines      = 7'($urandom_range(1, 64));
          idle       = 1'b0;
        end
        2: begin
          line_chars = 8'($urandom_range(1, 40));
          lines      = 7'($urandom_range(65, 127));
          idle       = 1'b1;
        end
        3: begin
          line_chars = 8'($urandom_range(1, 255));
          lines      = 7'($urandom_range(1, 8));
          idle       = 1'b1;
        end
        default: begin
          line_chars = 8'($urandom_range(3, 12));
          lines      = 7'd64;
          idle       = 1'b1;
        end
      endcase
      apply_setting(line_chars, lines, idle);
      mark = items_queued;
      while (items_queued - mark < 15) begin
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 10)) queue_byte(8'($urandom_range(0, 255)));
          queue_end();
        end else begin
          queue_text($urandom_range(1, 8), $urandom_range(1, 10));
        end
      end
    end

    wait_idle();
    $display("Run covered %0d text items over %0d register settings.",
             items_accepted, settings_used);
    $display("Checked %0d line results and %0d summaries, %0d mismatches.",
             lines_checked, summaries_seen, errors);
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("Timed out with %0d results still awaited.", awaited_results.size());
    $display("FAILURE");
    $finish;
  end

endmodule
